// File: src/dtpm_pkg.sv
// Shared types, command codes and constants for the decimal digit trie.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dtpm_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int NUM_W   = 30;
    localparam int LEN_W   = 4;
    localparam int DIGIT_W = 4;
    localparam int CNT_W   = 5;   // digit counts up to 31

    localparam int RADIX = 10;

    // Default sizes
    localparam int DEF_POOL_NODES = 1024;
    localparam int DEF_MAX_DIGITS = 9;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Divide by ten: q = (v * DIV10_RECIP) >> DIV10_SHIFT, exact for v < 2^32
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    // Largest value with the given number of decimal digits
    function automatic logic [63:0] max_value(input int digits);
        logic [63:0] acc;
        acc = 64'd1;
        for (int i = 0; i < digits; i++) begin
            acc = acc * 64'd10;
        end
        return acc - 64'd1;
    endfunction

    // Status from the digit splitter to the walk controller
    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] count;
    } t_split_stat;

endpackage

// File: src/dtpm_split.sv
// Digit splitter: saturates the number and peels decimal digits, one per cycle.
// Depends on dtpm_pkg. Digits are kept least significant first, read by index.
`timescale 1ns / 1ps

module dtpm_split #(
    parameter int MAX_DIGITS = dtpm_pkg::DEF_MAX_DIGITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [dtpm_pkg::NUM_W-1:0]   i_value,
    input  logic [dtpm_pkg::CNT_W-1:0]   i_idx,
    output logic [dtpm_pkg::DIGIT_W-1:0] o_digit,
    output dtpm_pkg::t_split_stat        o_stat
);
    import dtpm_pkg::*;

    localparam int          IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [63:0] LIMIT = max_value(MAX_DIGITS);

    logic [NUM_W-1:0]   r_val;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DIGIT_W-1:0] r_dig [2**IDX_W];

    logic [NUM_W-1:0]   sat_val;
    logic [61:0]        prod;
    logic [NUM_W-1:0]   quo;
    logic [NUM_W-1:0]   rem_full;
    logic               last_step;

    // Clamp to the largest value with MAX_DIGITS digits
    assign sat_val = ({34'd0, i_value} > LIMIT) ? LIMIT[NUM_W-1:0] : i_value;

    // One divide-by-ten step via reciprocal multiply
    assign prod      = r_val * DIV10_RECIP;
    assign quo       = NUM_W'(prod[61:DIV10_SHIFT]);
    assign rem_full  = r_val - ((quo << 3) + (quo << 1));
    assign last_step = (quo == '0) || (r_cnt + CNT_W'(1) == CNT_W'(MAX_DIGITS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_val  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_val  <= sat_val;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_val <= quo;
                r_cnt <= r_cnt + CNT_W'(1);
                if (last_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Digit buffer
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_dig[r_cnt[IDX_W-1:0]] <= rem_full[DIGIT_W-1:0];
        end
    end

    assign o_digit      = r_dig[i_idx[IDX_W-1:0]];
    assign o_stat.done  = r_done;
    assign o_stat.count = r_cnt;

endmodule

// File: src/dtpm_row_ram.sv
// Child-link row memory: one row of ten links per node, registered read.
// Depends on dtpm_pkg for its parameter defaults.
`timescale 1ns / 1ps

module dtpm_row_ram #(
    parameter int DEPTH = dtpm_pkg::DEF_POOL_NODES,
    parameter int WIDTH = dtpm_pkg::RADIX * $clog2(dtpm_pkg::DEF_POOL_NODES)
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    import dtpm_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/decimal_digit_trie_prefix_match.sv
// Decimal digit trie with longest prefix match; uses dtpm_pkg, dtpm_split, dtpm_row_ram.
// Flow: the splitter peels the digits, then each trie level takes a row read (S_RD) and
//   a check (S_CHK), each fresh node row a write (S_FRESH), and S_DONE registers the result.
// Clear: root row written in S_CLR; unused code: straight to S_DONE. One item at a time;
//   the next item is taken the cycle after the result is registered unless a result is held.
// Reset: S_INIT writes the root row; other rows are zeroed when allocated.
`timescale 1ns / 1ps

module decimal_digit_trie_prefix_match #(
    parameter int POOL_NODES = dtpm_pkg::DEF_POOL_NODES,
    parameter int MAX_DIGITS = dtpm_pkg::DEF_MAX_DIGITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [dtpm_pkg::CMD_W-1:0] i_cmd,
    input  logic [dtpm_pkg::NUM_W-1:0] i_number,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [dtpm_pkg::LEN_W-1:0] o_match_len,
    output logic [dtpm_pkg::LEN_W-1:0] o_best_len,
    output logic                       o_pool_full
);
    import dtpm_pkg::*;

    localparam int              NODE_W     = $clog2(POOL_NODES);
    localparam int              ROW_W      = RADIX * NODE_W;
    localparam logic [NODE_W:0] POOL_LIMIT = (NODE_W + 1)'(POOL_NODES);

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_SPLIT, S_RD, S_CHK, S_FRESH, S_CLR, S_DONE
    } t_state;

    t_state              r_state;
    logic [CMD_W-1:0]    r_cmd;
    logic [NODE_W-1:0]   r_node;
    logic [NODE_W:0]     r_used;
    logic [CNT_W-1:0]    r_left;
    logic [LEN_W-1:0]    r_match;
    logic [LEN_W-1:0]    r_best;
    logic                r_full;
    logic                r_out_valid;
    logic [LEN_W-1:0]    r_out_match;
    logic [LEN_W-1:0]    r_out_best;
    logic                r_out_full;

    logic                in_xfer;
    logic                split_start;
    t_split_stat         split_stat;
    logic [DIGIT_W-1:0]  dig;
    logic [ROW_W-1:0]    rd_row;
    logic [NODE_W-1:0]   cur_link;
    logic                link_hit;
    logic                pool_ok;
    logic [NODE_W-1:0]   new_link;
    logic [LEN_W-1:0]    n_best;

    logic                mem_we;
    logic                mem_re;
    logic [ROW_W-1:0]    w_base;
    logic                w_set;
    logic [ROW_W-1:0]    w_row;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign split_start = in_xfer && ((i_cmd == CMD_INSERT) || (i_cmd == CMD_QUERY));

    // Digit splitter
    dtpm_split #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (split_start),
        .i_value (i_number),
        .i_idx   (r_left - CNT_W'(1)),
        .o_digit (dig),
        .o_stat  (split_stat)
    );

    // Child-link rows
    dtpm_row_ram #(
        .DEPTH (POOL_NODES),
        .WIDTH (ROW_W)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_node),
        .i_wdata (w_row),
        .i_re    (mem_re),
        .i_raddr (r_node),
        .o_rdata (rd_row)
    );

    // Link lookup for the current digit
    assign cur_link = rd_row[int'(dig) * NODE_W +: NODE_W];
    assign link_hit = (cur_link != '0);
    assign pool_ok  = (r_used < POOL_LIMIT);
    assign new_link = r_used[NODE_W-1:0];
    assign n_best   = ((r_cmd == CMD_QUERY) && (r_match > r_best)) ? r_match : r_best;

    // Memory control: reads only in S_RD, writes only in other states
    always_comb begin
        mem_re = (r_state == S_RD);
        mem_we = 1'b0;
        w_base = '0;
        w_set  = 1'b0;
        unique case (r_state)
            S_INIT, S_CLR: begin
                mem_we = 1'b1;
            end
            S_CHK: begin
                mem_we = (r_cmd == CMD_INSERT) && !link_hit && pool_ok;
                w_base = rd_row;
                w_set  = 1'b1;
            end
            S_FRESH: begin
                mem_we = 1'b1;
                w_set  = (r_left != '0) && pool_ok;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Row with the current digit's link pointed at the next free node
    always_comb begin
        w_row = w_base;
        for (int k = 0; k < RADIX; k++) begin
            if (w_set && (int'(dig) == k)) begin
                w_row[k * NODE_W +: NODE_W] = new_link;
            end
        end
    end

    // Walk controller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cmd       <= CMD_INSERT;
            r_node      <= '0;
            r_used      <= (NODE_W + 1)'(1);
            r_left      <= '0;
            r_match     <= '0;
            r_best      <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_match <= '0;
            r_out_best  <= '0;
            r_out_full  <= 1'b0;
        end else begin
            // Result register drains on a transfer; S_DONE refills it
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cmd   <= i_cmd;
                        r_node  <= '0;
                        r_match <= '0;
                        r_full  <= 1'b0;
                        case (i_cmd)
                            CMD_INSERT, CMD_QUERY: begin
                                r_state <= S_SPLIT;
                            end
                            CMD_CLEAR: begin
                                r_used  <= (NODE_W + 1)'(1);
                                r_best  <= '0;
                                r_state <= S_CLR;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SPLIT: begin
                    if (split_stat.done) begin
                        r_left  <= split_stat.count;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (link_hit) begin
                        r_node <= cur_link;
                        r_left <= r_left - CNT_W'(1);
                        if (r_cmd == CMD_QUERY) begin
                            r_match <= r_match + LEN_W'(1);
                        end
                        r_state <= (r_left == CNT_W'(1)) ? S_DONE : S_RD;
                    end else if ((r_cmd == CMD_INSERT) && pool_ok) begin
                        r_node  <= new_link;
                        r_used  <= r_used + (NODE_W + 1)'(1);
                        r_left  <= r_left - CNT_W'(1);
                        r_state <= S_FRESH;
                    end else begin
                        r_full  <= (r_cmd == CMD_INSERT);
                        r_state <= S_DONE;
                    end
                end
                S_FRESH: begin
                    // Each fresh row is written once: zero, or one link to the next node
                    if (r_left == '0) begin
                        r_state <= S_DONE;
                    end else if (pool_ok) begin
                        r_node <= new_link;
                        r_used <= r_used + (NODE_W + 1)'(1);
                        r_left <= r_left - CNT_W'(1);
                    end else begin
                        r_full  <= 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_CLR: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_match <= r_match;
                        r_out_best  <= n_best;
                        r_out_full  <= r_full;
                        r_best      <= n_best;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_match_len = r_out_match;
    assign o_best_len  = r_out_best;
    assign o_pool_full = r_out_full;

    // Checks
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("row read and write in the same cycle");

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != '0) && (r_used <= POOL_LIMIT))
        else $error("node count out of range");

    a_chk_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (r_left != '0))
        else $error("link check with no digit left");

    a_best_covers_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_best_len >= o_match_len))
        else $error("best length below match length");

    a_clear_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_cmd == CMD_CLEAR)) |=> ((r_used == (NODE_W + 1)'(1)) && (r_best == '0)))
        else $error("clear did not reset the pool");

endmodule

// File: tb/dtpm_result_checker.sv
// Checker for the decimal digit trie: watches both channels, predicts every result
// and compares it with what the block returns. Depends on dtpm_pkg.
`timescale 1ns / 1ps

module dtpm_result_checker #(
    parameter int POOL_NODES = dtpm_pkg::DEF_POOL_NODES,
    parameter int MAX_DIGITS = dtpm_pkg::DEF_MAX_DIGITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [dtpm_pkg::CMD_W-1:0] i_cmd,
    input  logic [dtpm_pkg::NUM_W-1:0] i_number,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [dtpm_pkg::LEN_W-1:0] i_match_len,
    input  logic [dtpm_pkg::LEN_W-1:0] i_best_len,
    input  logic                       i_pool_full,
    output int                         o_errors,
    output int                         o_pending
);

    import dtpm_pkg::*;

    typedef struct packed {
        logic [LEN_W-1:0] match_len;
        logic [LEN_W-1:0] best_len;
        logic             pool_full;
    } t_trie_result;

    // Shadow copy of the trie
    int unsigned  child_link [POOL_NODES*RADIX];
    int unsigned  node_count;
    int unsigned  best_depth;

    t_trie_result expected_results [$];
    t_trie_result oldest;
    t_trie_result predicted;
    int           error_count = 0;

    assign o_errors = error_count;

    // Empty the trie: root only, no links, running best back to zero
    task automatic trie_empty();
        for (int i = 0; i < POOL_NODES*RADIX; i++) begin
            child_link[i] = 0;
        end
        node_count = 1;
        best_depth = 0;
    endtask

    // Apply one command to the shadow trie and build its result
    task automatic trie_step(input logic [CMD_W-1:0] cmd, input logic [NUM_W-1:0] num,
                             output t_trie_result res);
        longint unsigned value;
        longint unsigned cap;
        int unsigned     rev [MAX_DIGITS];
        int unsigned     digits [MAX_DIGITS];
        int              ndig;
        int unsigned     node;
        int unsigned     slot;
        int unsigned     next;
        int unsigned     depth;
        logic            stop;
        logic            ran_out;

        // Digits, most significant first; oversize values saturate
        cap = 1;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            cap = cap * RADIX;
        end
        cap   = cap - 1;
        value = 64'(num);
        if (value > cap) begin
            value = cap;
        end
        ndig = 0;
        do begin
            rev[ndig] = 32'(value % RADIX);
            value     = value / RADIX;
            ndig++;
        end while (value != 0 && ndig < MAX_DIGITS);
        for (int i = 0; i < ndig; i++) begin
            digits[i] = rev[ndig-1-i];
        end

        node    = 0;
        depth   = 0;
        stop    = 1'b0;
        ran_out = 1'b0;
        case (cmd)
            CMD_INSERT: begin
                // Walk down, allocating missing nodes until the pool runs dry
                for (int i = 0; i < ndig && !ran_out; i++) begin
                    slot = node*RADIX + digits[i];
                    if (child_link[slot] == 0) begin
                        if (node_count >= POOL_NODES) begin
                            ran_out = 1'b1;
                        end else begin
                            child_link[slot] = node_count;
                            node_count++;
                        end
                    end
                    if (!ran_out) begin
                        node = child_link[slot];
                    end
                end
            end
            CMD_QUERY: begin
                for (int i = 0; i < ndig && !stop; i++) begin
                    next = child_link[node*RADIX + digits[i]];
                    if (next == 0 || next >= POOL_NODES) begin
                        stop = 1'b1;
                    end else begin
                        node = next;
                        depth++;
                    end
                end
                if (depth > best_depth) begin
                    best_depth = depth;
                end
            end
            CMD_CLEAR: begin
                trie_empty();
            end
            default: begin
                // unused code: no state change
            end
        endcase

        res.match_len = depth[LEN_W-1:0];
        res.best_len  = best_depth[LEN_W-1:0];
        res.pool_full = ran_out;
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    // Result side first, so a result can never match an item taken on the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            trie_empty();
            expected_results.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result with nothing expected, actual %0d/%0d/%0d",
                             $time, i_match_len, i_best_len, i_pool_full);
                    error_count++;
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("match_len", int'(oldest.match_len), int'(i_match_len));
                    check_field("best_len", int'(oldest.best_len), int'(i_best_len));
                    check_field("pool_full", int'(oldest.pool_full), int'(i_pool_full));
                end
            end
            if (i_in_valid && i_in_ready) begin
                trie_step(i_cmd, i_number, predicted);
                expected_results.push_back(predicted);
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

// File: tb/decimal_digit_trie_prefix_match_test.sv
// Testbench top for decimal_digit_trie_prefix_match: drives commands with bursty
// traffic and a stalling receiver; checking lives in dtpm_result_checker.
`timescale 1ns / 1ps

module decimal_digit_trie_prefix_match_test;

    import dtpm_pkg::*;

    localparam int POOL_NODES  = 1024;
    localparam int MAX_DIGITS  = 9;
    localparam int ITEM_TARGET = 410;    // directed plus random work items
    localparam int IDLE_LIMIT  = 2000;   // cycles with no transfer before giving up
    localparam int TAIL_CYCLES = 40;
    localparam int FILL_INSERTS = 170;

    // Code the block does not use; must leave the trie alone
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam logic [NUM_W-1:0] NUM_ALL_ONES = '1;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic [CMD_W-1:0] cmd       = CMD_INSERT;
    logic [NUM_W-1:0] number    = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [LEN_W-1:0] match_len;
    logic [LEN_W-1:0] best_len;
    logic             pool_full;

    int errors;
    int pending;

    int          burst_left = 0;
    int          work_items = 0;
    int unsigned stored_keys [$];

    initial forever #6 clk = ~clk;

    decimal_digit_trie_prefix_match #(
        .POOL_NODES (POOL_NODES),
        .MAX_DIGITS (MAX_DIGITS)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_cmd       (cmd),
        .i_number    (number),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_match_len (match_len),
        .o_best_len  (best_len),
        .o_pool_full (pool_full)
    );

    dtpm_result_checker #(
        .POOL_NODES (POOL_NODES),
        .MAX_DIGITS (MAX_DIGITS)
    ) checker_inst (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_cmd       (cmd),
        .i_number    (number),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_match_len (match_len),
        .i_best_len  (best_len),
        .i_pool_full (pool_full),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Receiver: a randomly chosen stall mode, held for a random stretch, drives out_ready
    int unsigned stall_mode  = 0;
    int unsigned mode_left   = 0;
    int unsigned cycle_count = 0;

    always @(posedge clk) begin
        cycle_count++;
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 120);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 1);
            2:       out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= ((cycle_count % 9) < 2);
        endcase
    end

    // Watchdog: give up after too many cycles without any transfer
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("[decimal_digit_trie_prefix_match] ERROR");
        $finish;
    end

    // One transfer on the input side; bursts with random gaps between them
    task automatic send_item(input logic [CMD_W-1:0] c, input logic [NUM_W-1:0] n);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd      <= c;
        number   <= n;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        // keys kept only to aim queries at existing paths
        if (c == CMD_INSERT) begin
            stored_keys.push_back(n);
        end else if (c == CMD_CLEAR) begin
            stored_keys.delete();
        end
        if (c != CMD_NOP) begin
            work_items++;
        end
    endtask

    // Hold the sender until every outstanding result is back
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [NUM_W-1:0] pick_key();
        case ($urandom_range(0, 3))
            0:       return NUM_W'($urandom_range(0, 99));
            1:       return NUM_W'($urandom_range(0, 99999));
            2:       return NUM_W'($urandom_range(100000000, 999999999));
            default: return NUM_W'($urandom);
        endcase
    endfunction

    // Number near a stored key: same, tail replaced, or a prefix of it
    function automatic logic [NUM_W-1:0] related_key();
        int unsigned base;
        int unsigned scale;
        int unsigned k;
        base  = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        k     = $urandom_range(0, 4);
        scale = 1;
        repeat (k) scale = scale * 10;
        case ($urandom_range(0, 2))
            0:       return NUM_W'(base);
            1:       return NUM_W'((base / scale) * scale + $urandom_range(0, scale - 1));
            default: return NUM_W'(base / scale);
        endcase
    endfunction

    task automatic send_mixed_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            send_item(CMD_INSERT, pick_key());
        end else if (r < 80 && stored_keys.size() != 0) begin
            send_item(CMD_QUERY, related_key());
        end else if (r < 88) begin
            send_item(CMD_QUERY, pick_key());
        end else if (r < 93) begin
            send_item(CMD_NOP, NUM_W'($urandom));
        end else if (r < 96) begin
            send_item(CMD_CLEAR, NUM_W'($urandom));
        end else begin
            send_item($urandom_range(0, 1) ? CMD_QUERY : CMD_INSERT, NUM_W'($urandom));
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty trie, zero, largest keys, saturation, prefixes, unused code
        send_item(CMD_QUERY, 0);
        send_item(CMD_INSERT, 0);
        send_item(CMD_QUERY, 0);
        send_item(CMD_INSERT, 999999999);
        send_item(CMD_QUERY, 999999999);
        send_item(CMD_QUERY, NUM_ALL_ONES);
        send_item(CMD_INSERT, NUM_ALL_ONES);
        send_item(CMD_QUERY, 999999998);
        send_item(CMD_QUERY, 12345);
        send_item(CMD_INSERT, 12345);
        send_item(CMD_QUERY, 123);
        send_item(CMD_QUERY, 123456789);
        send_item(CMD_QUERY, 12399);
        send_item(CMD_NOP, NUM_ALL_ONES);
        send_item(CMD_QUERY, 5);
        send_item(CMD_CLEAR, 0);
        send_item(CMD_QUERY, 12345);
        send_item(CMD_INSERT, 7);
        send_item(CMD_QUERY, 7);
        send_item(CMD_QUERY, 70);
        send_item(CMD_NOP, 0);
        send_item(CMD_CLEAR, NUM_ALL_ONES);
        wait_results_drained();

        // Fill the pool with long keys, probing as it goes, then keep working on a full pool
        for (int i = 0; i < FILL_INSERTS; i++) begin
            send_item(CMD_INSERT, NUM_W'($urandom_range(100000000, 999999999)));
            if ($urandom_range(0, 3) == 0) begin
                send_item(CMD_QUERY, related_key());
            end
        end
        repeat (40) send_mixed_item();

        // Short sessions, each starting from an empty trie
        while (work_items < ITEM_TARGET) begin
            if ($urandom_range(0, 2) == 0) begin
                wait_results_drained();
            end
            send_item(CMD_CLEAR, NUM_W'($urandom));
            repeat ($urandom_range(15, 60)) send_mixed_item();
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("[decimal_digit_trie_prefix_match] OK");
        end else begin
            $display("[decimal_digit_trie_prefix_match] ERROR");
        end
        $finish;
    end

endmodule

// File: decimal_digit_trie_prefix_match.f
src/dtpm_pkg.sv
src/dtpm_split.sv
src/dtpm_row_ram.sv
src/decimal_digit_trie_prefix_match.sv
tb/dtpm_result_checker.sv
tb/decimal_digit_trie_prefix_match_test.sv
